@@ design/sgdm_pkg.sv @@
// ----------------------------------------------------------------------------
// SGD momentum update package
// Shared widths, word types, register indexes and fixed-point helpers.
// ----------------------------------------------------------------------------
package sgdm_pkg;

  localparam int DW    = 32;  // data width, signed fixed point
  localparam int FB    = 24;  // fraction bits
  localparam int LRW   = 31;
  localparam int WDW   = 32;
  localparam int MFW   = 32;
  localparam int DPW   = 25;
  localparam int GSW   = 31;
  localparam int MODEW = 6;
  localparam int CIW   = 3;   // configuration index width
  localparam int WW    = 2 * DW + 2;

  localparam int MODE_NESTEROV = 0;
  localparam int MODE_MAXIMIZE = 1;
  localparam int MODE_FIRST    = 2;
  localparam int MODE_MOMENTUM = 3;
  localparam int MODE_UNSCALE  = 4;
  localparam int MODE_SKIP     = 5;

  localparam logic [GSW-1:0] GRAD_SCALE_RESET = GSW'(1) << FB;

  typedef enum logic [CIW-1:0] {
    REG_LR    = 3'd0,
    REG_WD    = 3'd1,
    REG_MOM   = 3'd2,
    REG_DAMP  = 3'd3,
    REG_SCALE = 3'd4,
    REG_MODE  = 3'd5
  } cfg_reg_t;

  typedef logic signed [DW-1:0] data_t;
  typedef logic signed [DW:0]   coef_t;

  localparam data_t DMAX = {1'b0, {(DW-1){1'b1}}};
  localparam data_t DMIN = {1'b1, {(DW-1){1'b0}}};
  localparam coef_t ONE_Q = coef_t'(1) <<< FB;

  typedef struct packed {
    data_t param_in;
    data_t grad_in;
    data_t momentum_in;
  } in_word_t;

  typedef struct packed {
    data_t param_out;
    data_t grad_out;
    data_t momentum_out;
  } out_word_t;

  function automatic data_t sat_w(input logic signed [WW-1:0] x);
    logic signed [WW-1:0] hi;
    logic signed [WW-1:0] lo;
    hi = WW'(DMAX);
    lo = WW'(DMIN);
    if (x > hi) return DMAX;
    if (x < lo) return DMIN;
    return x[DW-1:0];
  endfunction

  // Exact product, floored by FB fraction bits, then saturated.
  function automatic data_t mulq(input coef_t a, input data_t b);
    logic signed [2*DW:0] prod;
    logic signed [2*DW:0] shifted;
    prod    = a * b;
    shifted = prod >>> FB;
    return sat_w(WW'(shifted));
  endfunction

  function automatic data_t add_sat(input data_t a, input data_t b);
    return sat_w(WW'(a) + WW'(b));
  endfunction

  function automatic data_t sub_sat(input data_t a, input data_t b);
    return sat_w(WW'(a) - WW'(b));
  endfunction

endpackage

@@ design/sgd_momentum_update_core.sv @@
// ----------------------------------------------------------------------------
// SGD momentum update core
// Element-wise SGD step with loss unscale, maximize, weight decay, momentum
// and Nesterov in signed Q8.24, with saturating sums and floored products.
// ----------------------------------------------------------------------------
// Usage:
//   Input words (param, grad, momentum) arrive on in_valid/in_word and are
//   taken on any edge with in_valid high and in_stall low. Result words leave
//   on out_valid/out_word and are taken when out_stall is low.
//   Registers are written on cfg_valid with cfg_ready (always high); index
//   selects learning rate, weight decay, momentum, dampening, grad scale or
//   mode flags. Indexes above the mode register are ignored. Write them only
//   while no word is in flight.
//   The pipeline has 34 stages of the unscale divider (one quotient bit
//   per stage plus setup and rounding) and 8 update stages. One word is taken
//   every cycle while in_stall is low.
//   Reset clears all valid bits and restores register defaults (grad scale
//   1.0, all others zero). While out_stall is high with a word waiting, the
//   whole pipeline holds and in_stall is raised; nothing is dropped.
// ----------------------------------------------------------------------------
module sgd_momentum_update_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  sgdm_pkg::in_word_t            in_word,
  output logic                          out_valid,
  input  logic                          out_stall,
  output sgdm_pkg::out_word_t           out_word,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [sgdm_pkg::CIW-1:0]      cfg_index,
  input  logic [31:0]                   cfg_data
);

  logic [sgdm_pkg::LRW-1:0]   learning_rate;
  logic [sgdm_pkg::WDW-1:0]   decay_coef;
  logic [sgdm_pkg::MFW-1:0]   momentum_factor;
  logic [sgdm_pkg::DPW-1:0]   dampening;
  logic [sgdm_pkg::GSW-1:0]   grad_scale;
  logic [sgdm_pkg::MODEW-1:0] mode_flags;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      learning_rate   <= '0;
      decay_coef      <= '0;
      momentum_factor <= '0;
      dampening       <= '0;
      grad_scale      <= sgdm_pkg::GRAD_SCALE_RESET;
      mode_flags      <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        sgdm_pkg::REG_LR:    learning_rate   <= cfg_data[sgdm_pkg::LRW-1:0];
        sgdm_pkg::REG_WD:    decay_coef      <= cfg_data[sgdm_pkg::WDW-1:0];
        sgdm_pkg::REG_MOM:   momentum_factor <= cfg_data[sgdm_pkg::MFW-1:0];
        sgdm_pkg::REG_DAMP:  dampening       <= cfg_data[sgdm_pkg::DPW-1:0];
        sgdm_pkg::REG_SCALE: grad_scale      <= cfg_data[sgdm_pkg::GSW-1:0];
        sgdm_pkg::REG_MODE:  mode_flags      <= cfg_data[sgdm_pkg::MODEW-1:0];
        default: ;
      endcase
    end
  end

  // The pipeline moves as a whole whenever the output register is free.
  logic adv;
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  logic               div_valid;
  sgdm_pkg::in_word_t div_word;
  sgdm_pkg::data_t    div_quot;

  sgdm_div u_div (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (in_valid),
    .in_word   (in_word),
    .scale     (grad_scale),
    .out_valid (div_valid),
    .out_word  (div_word),
    .quot      (div_quot)
  );

  sgdm_update u_update (
    .clk             (clk),
    .rst             (rst),
    .adv             (adv),
    .in_valid        (div_valid),
    .in_word         (div_word),
    .quot            (div_quot),
    .learning_rate   (learning_rate),
    .decay_coef      (decay_coef),
    .momentum_factor (momentum_factor),
    .dampening       (dampening),
    .mode_flags      (mode_flags),
    .out_valid       (out_valid),
    .out_word        (out_word)
  );

endmodule

@@ design/sgdm_div.sv @@
// ----------------------------------------------------------------------------
// SGD momentum gradient unscale divider
// Pipelined restoring divider, one quotient bit per stage, computing the
// floored and saturated quotient (grad * 2^FB) / scale.
// ----------------------------------------------------------------------------
module sgdm_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       adv,
  input  logic                       in_valid,
  input  sgdm_pkg::in_word_t         in_word,
  input  logic [sgdm_pkg::GSW-1:0]   scale,
  output logic                       out_valid,
  output sgdm_pkg::in_word_t         out_word,
  output sgdm_pkg::data_t            quot
);

  localparam int DW  = sgdm_pkg::DW;
  localparam int FB  = sgdm_pkg::FB;
  localparam int GSW = sgdm_pkg::GSW;

  typedef struct packed {
    sgdm_pkg::in_word_t w;
    logic               neg;
    logic               zero;
    logic               ovf;
    logic [GSW-1:0]     rem;
    logic [DW-1:0]      lo;
    logic [DW-1:0]      q;
  } div_st_t;

  div_st_t        st  [0:DW];
  logic [DW:0]    vld;

  // Operand preparation: magnitude, overflow check on the top bits.
  logic [DW-1:0]    mag;
  logic [DW+FB-1:0] num;
  logic [FB-1:0]    num_hi;
  logic             pre_ovf;
  div_st_t          pre;

  always_comb begin
    mag     = in_word.grad_in[DW-1] ? DW'(-in_word.grad_in) : DW'(in_word.grad_in);
    num     = {mag, {FB{1'b0}}};
    num_hi  = num[DW+FB-1:DW];
    if (scale == '0) begin
      pre_ovf = (in_word.grad_in != '0);
    end else begin
      pre_ovf = ({{(GSW-FB){1'b0}}, num_hi} >= scale);
    end
    pre.w    = in_word;
    pre.neg  = in_word.grad_in[DW-1];
    pre.zero = (in_word.grad_in == '0);
    pre.ovf  = pre_ovf;
    pre.rem  = {{(GSW-FB){1'b0}}, num_hi};
    pre.lo   = num[DW-1:0];
    pre.q    = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (adv) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st[0] <= pre;
    end
  end

  for (genvar k = 0; k < DW; k++) begin : g_stage
    logic [GSW:0] trial;
    logic         take;
    div_st_t      nxt;

    always_comb begin
      trial = {st[k].rem, st[k].lo[DW-1]};
      take  = (trial >= {1'b0, scale});
      nxt      = st[k];
      nxt.rem  = take ? GSW'(trial - {1'b0, scale}) : trial[GSW-1:0];
      nxt.lo   = {st[k].lo[DW-2:0], 1'b0};
      nxt.q    = {st[k].q[DW-2:0], take};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (adv) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        st[k+1] <= nxt;
      end
    end
  end

  // Sign, rounding toward minus infinity and saturation.
  logic [DW:0]     ceil_q;
  sgdm_pkg::data_t res;

  always_comb begin
    ceil_q = {1'b0, st[DW].q} + {{DW{1'b0}}, (st[DW].rem != '0)};
    if (st[DW].zero) begin
      res = '0;
    end else if (!st[DW].neg) begin
      res = (st[DW].ovf || st[DW].q[DW-1]) ? sgdm_pkg::DMAX : st[DW].q;
    end else if (st[DW].ovf || ceil_q > ({1'b0, {DW{1'b0}}} | ((DW+1)'(1) << (DW-1)))) begin
      res = sgdm_pkg::DMIN;
    end else begin
      res = DW'(-ceil_q);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= vld[DW];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_word <= st[DW].w;
      quot     <= res;
    end
  end

endmodule

@@ design/sgdm_update.sv @@
// ----------------------------------------------------------------------------
// SGD momentum update datapath
// Eight register stages: unscale select, maximize, weight decay, momentum
// buffer, Nesterov term, parameter step or skip; at most one multiply per stage.
// ----------------------------------------------------------------------------
module sgdm_update (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         adv,
  input  logic                         in_valid,
  input  sgdm_pkg::in_word_t           in_word,
  input  sgdm_pkg::data_t              quot,
  input  logic [sgdm_pkg::LRW-1:0]     learning_rate,
  input  logic [sgdm_pkg::WDW-1:0]     decay_coef,
  input  logic [sgdm_pkg::MFW-1:0]     momentum_factor,
  input  logic [sgdm_pkg::DPW-1:0]     dampening,
  input  logic [sgdm_pkg::MODEW-1:0]   mode_flags,
  output logic                         out_valid,
  output sgdm_pkg::out_word_t          out_word
);

  localparam int DW = sgdm_pkg::DW;

  typedef struct packed {
    sgdm_pkg::in_word_t orig;
    sgdm_pkg::data_t    g;
    sgdm_pkg::data_t    g_out;
    sgdm_pkg::data_t    b;
    sgdm_pkg::data_t    t1;
    sgdm_pkg::data_t    t2;
  } upd_st_t;

  localparam int NST = 7;

  upd_st_t         st  [1:NST];
  logic [NST:1]    vld;

  sgdm_pkg::coef_t lr_c;
  sgdm_pkg::coef_t wd_c;
  sgdm_pkg::coef_t mom_c;
  sgdm_pkg::coef_t keep_c;
  logic            nesterov;
  logic            maximize;
  logic            first;
  logic            use_mom;
  logic            unscale;
  logic            skip;

  always_comb begin
    lr_c     = {2'b00, learning_rate};
    wd_c     = {decay_coef[sgdm_pkg::WDW-1], decay_coef};
    mom_c    = {momentum_factor[sgdm_pkg::MFW-1], momentum_factor};
    keep_c   = sgdm_pkg::ONE_Q - $signed({{(DW+1-sgdm_pkg::DPW){1'b0}}, dampening});
    nesterov = mode_flags[sgdm_pkg::MODE_NESTEROV];
    maximize = mode_flags[sgdm_pkg::MODE_MAXIMIZE];
    first    = mode_flags[sgdm_pkg::MODE_FIRST];
    use_mom  = mode_flags[sgdm_pkg::MODE_MOMENTUM];
    unscale  = mode_flags[sgdm_pkg::MODE_UNSCALE];
    skip     = mode_flags[sgdm_pkg::MODE_SKIP];
  end

  upd_st_t n1, n2, n3, n4, n5, n6, n7;
  sgdm_pkg::data_t g0;

  always_comb begin
    // Stage 1: unscale select, maximize, weight decay product.
    g0       = unscale ? quot : in_word.grad_in;
    n1.orig  = in_word;
    n1.g_out = g0;
    n1.g     = maximize ? sgdm_pkg::sub_sat('0, g0) : g0;
    n1.b     = in_word.momentum_in;
    n1.t1    = sgdm_pkg::mulq(wd_c, in_word.param_in);
    n1.t2    = '0;

    // Stage 2: weight decay sum, momentum times old buffer.
    n2    = st[1];
    n2.g  = (decay_coef != '0) ? sgdm_pkg::add_sat(st[1].g, st[1].t1) : st[1].g;
    n2.t1 = sgdm_pkg::mulq(mom_c, st[1].b);

    // Stage 3: weighted gradient.
    n3    = st[2];
    n3.t2 = sgdm_pkg::mulq(keep_c, st[2].g);

    // Stage 4: new buffer.
    n4 = st[3];
    if (use_mom) begin
      n4.b = first ? st[3].g : sgdm_pkg::add_sat(st[3].t1, st[3].t2);
    end

    // Stage 5: Nesterov product with the new buffer.
    n5    = st[4];
    n5.t1 = sgdm_pkg::mulq(mom_c, st[4].b);

    // Stage 6: effective gradient.
    n6 = st[5];
    if (use_mom) begin
      n6.g = nesterov ? sgdm_pkg::add_sat(st[5].g, st[5].t1) : st[5].b;
    end

    // Stage 7: step product.
    n7    = st[6];
    n7.t1 = sgdm_pkg::mulq(lr_c, st[6].g);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else if (adv) begin
      vld       <= {vld[NST-1:1], in_valid};
      out_valid <= vld[NST];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st[1] <= n1;
      st[2] <= n2;
      st[3] <= n3;
      st[4] <= n4;
      st[5] <= n5;
      st[6] <= n6;
      st[7] <= n7;
      if (skip) begin
        out_word.param_out    <= st[7].orig.param_in;
        out_word.grad_out     <= st[7].orig.grad_in;
        out_word.momentum_out <= st[7].orig.momentum_in;
      end else begin
        out_word.param_out    <= sgdm_pkg::sub_sat(st[7].orig.param_in, st[7].t1);
        out_word.grad_out     <= st[7].g_out;
        out_word.momentum_out <= st[7].b;
      end
    end
  end

endmodule

@@ tb/sgd_momentum_update_checker.sv @@
// ----------------------------------------------------------------------------
// SGD momentum update checker
// Watches the input and result channels, computes the expected result of each
// accepted input word in fixed point and compares it field by field.
// ----------------------------------------------------------------------------
module sgd_momentum_update_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  sgdm_pkg::in_word_t            in_word,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  sgdm_pkg::out_word_t           out_word,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [sgdm_pkg::CIW-1:0]      cfg_index,
  input  logic [31:0]                   cfg_data,
  output int                            errors,
  output int                            pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [sgdm_pkg::LRW-1:0]   lr_q;
  logic [sgdm_pkg::WDW-1:0]   wd_q;
  logic [sgdm_pkg::MFW-1:0]   mom_q;
  logic [sgdm_pkg::DPW-1:0]   damp_q;
  logic [sgdm_pkg::GSW-1:0]   scale_q;
  logic [sgdm_pkg::MODEW-1:0] mode_q;

  sgdm_pkg::out_word_t expected_updates[$];

  initial errors = 0;
  assign pending = expected_updates.size();

  function automatic longint clamp(input longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  // Product floored by the fraction bits; arithmetic shift floors.
  function automatic longint fmul(input longint a, input longint b);
    return clamp((a * b) >>> sgdm_pkg::FB);
  endfunction

  function automatic longint fdiv(input longint g, input longint s);
    longint n;
    if (s <= 0) return (g > 0) ? 64'sd2147483647 : (g < 0) ? -64'sd2147483648 : 0;
    n = g <<< sgdm_pkg::FB;
    if (n >= 0) return clamp(n / s);
    return clamp(-((-n + s - 1) / s));
  endfunction

  function automatic sgdm_pkg::out_word_t predict_update(input sgdm_pkg::in_word_t w);
    sgdm_pkg::out_word_t r;
    longint p, g, b, gout, keep, mom;
    p = longint'(w.param_in);
    g = longint'(w.grad_in);
    b = longint'(w.momentum_in);
    gout = g;
    mom = longint'($signed(mom_q));
    if (!mode_q[sgdm_pkg::MODE_SKIP]) begin
      if (mode_q[sgdm_pkg::MODE_UNSCALE]) begin
        g = fdiv(g, longint'(scale_q));
        gout = g;
      end
      if (mode_q[sgdm_pkg::MODE_MAXIMIZE]) g = clamp(-g);
      if (wd_q != 0) g = clamp(g + fmul(longint'($signed(wd_q)), p));
      if (mode_q[sgdm_pkg::MODE_MOMENTUM]) begin
        keep = (64'sd1 <<< sgdm_pkg::FB) - longint'(damp_q);
        if (mode_q[sgdm_pkg::MODE_FIRST]) b = g;
        else b = clamp(fmul(mom, b) + fmul(keep, g));
        if (mode_q[sgdm_pkg::MODE_NESTEROV]) g = clamp(g + fmul(mom, b));
        else g = b;
      end
      p = clamp(p - fmul(longint'(lr_q), g));
    end
    r.param_out = sgdm_pkg::data_t'(p);
    r.grad_out = sgdm_pkg::data_t'(gout);
    r.momentum_out = sgdm_pkg::data_t'(b);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input sgdm_pkg::data_t got,
                                 input sgdm_pkg::data_t want);
    $display("%0t: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    sgdm_pkg::out_word_t want;
    if (rst) begin
      lr_q <= '0;
      wd_q <= '0;
      mom_q <= '0;
      damp_q <= '0;
      scale_q <= sgdm_pkg::GRAD_SCALE_RESET;
      mode_q <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (sgdm_pkg::cfg_reg_t'(cfg_index))
          sgdm_pkg::REG_LR:    lr_q <= cfg_data[sgdm_pkg::LRW-1:0];
          sgdm_pkg::REG_WD:    wd_q <= cfg_data[sgdm_pkg::WDW-1:0];
          sgdm_pkg::REG_MOM:   mom_q <= cfg_data[sgdm_pkg::MFW-1:0];
          sgdm_pkg::REG_DAMP:  damp_q <= cfg_data[sgdm_pkg::DPW-1:0];
          sgdm_pkg::REG_SCALE: scale_q <= cfg_data[sgdm_pkg::GSW-1:0];
          sgdm_pkg::REG_MODE:  mode_q <= cfg_data[sgdm_pkg::MODEW-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) expected_updates.push_back(predict_update(in_word));
      if (out_valid && !out_stall) begin
        if (expected_updates.size() == 0) begin
          $display("%0t: result word with nothing expected", $realtime);
          errors++;
        end else begin
          want = expected_updates.pop_front();
          if (out_word.param_out !== want.param_out)
            report_mismatch("param_out", out_word.param_out, want.param_out);
          if (out_word.grad_out !== want.grad_out)
            report_mismatch("grad_out", out_word.grad_out, want.grad_out);
          if (out_word.momentum_out !== want.momentum_out)
            report_mismatch("momentum_out", out_word.momentum_out, want.momentum_out);
        end
      end
    end
  end

endmodule

@@ tb/sgd_momentum_update_core_test.sv @@
// ----------------------------------------------------------------------------
// SGD momentum update core testbench
// Drives directed and random words through several register settings with
// random gaps and output stalls; the checker predicts and compares results.
// ----------------------------------------------------------------------------
module sgd_momentum_update_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  // An index past the last register; writes to it must be ignored.
  localparam logic [sgdm_pkg::CIW-1:0] REG_UNMAPPED = 3'd7;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  sgdm_pkg::in_word_t in_word = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  sgdm_pkg::out_word_t out_word;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [sgdm_pkg::CIW-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  int errors;
  int pending;
  int hold_off = 0;
  bit stall_random = 1'b1;

  always #4 clk = ~clk;

  sgd_momentum_update_core i_dut (.*);

  sgd_momentum_update_checker i_checker (.*);

  task automatic write_reg(input logic [sgdm_pkg::CIW-1:0] idx, input logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_word(input sgdm_pkg::data_t p, input sgdm_pkg::data_t g,
                           input sgdm_pkg::data_t b);
    in_valid <= 1'b1;
    in_word <= '{p, g, b};
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  function automatic sgdm_pkg::data_t pick_value();
    case ($urandom_range(0, 7))
      0: return sgdm_pkg::DMAX;
      1: return sgdm_pkg::DMIN;
      2: return sgdm_pkg::data_t'($urandom_range(0, 3)) - 1;
      3: return sgdm_pkg::data_t'($signed($urandom_range(0, 32'h01ff_ffff)) - 32'sh0100_0000);
      default: return sgdm_pkg::data_t'($urandom);
    endcase
  endfunction

  // Random words in bursts; between bursts the sender sometimes goes idle for a random gap.
  task automatic send_random(input int count);
    int burst;
    int i;
    burst = 0;
    for (i = 0; i < count; i++) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 20);
        if ($urandom_range(0, 1)) begin
          in_valid <= 1'b0;
          repeat ($urandom_range(1, 6)) @(posedge clk);
        end
      end
      send_word(pick_value(), pick_value(), pick_value());
      burst--;
    end
    in_valid <= 1'b0;
  endtask

  task automatic drain;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic random_config;
    write_reg(sgdm_pkg::REG_LR,
              $urandom_range(0, 3) == 0 ? 32'h7fff_ffff : $urandom_range(0, 32'h0200_0000));
    write_reg(sgdm_pkg::REG_WD,
              $urandom_range(0, 2) == 0 ? 32'h0 : sgdm_pkg::data_t'($urandom));
    write_reg(sgdm_pkg::REG_MOM,
              $urandom_range(0, 3) == 0 ? 32'h8000_0000 : $urandom_range(0, 32'h0100_0000));
    write_reg(sgdm_pkg::REG_DAMP,
              $urandom_range(0, 3) == 0 ? 32'h01ff_ffff : $urandom_range(0, 32'h0100_0000));
    write_reg(sgdm_pkg::REG_SCALE,
              $urandom_range(0, 4) == 0 ? 32'h0 : $urandom_range(1, 32'h7fff_ffff));
    write_reg(sgdm_pkg::REG_MODE, $urandom_range(0, 63));
  endtask

  // Output stall pattern; a hold-off request forces a long stall.
  always @(posedge clk) begin
    if (hold_off > 0) begin
      out_stall <= 1'b1;
      hold_off <= hold_off - 1;
    end else if (stall_random) begin
      out_stall <= ($urandom_range(0, 3) == 0);
    end else begin
      out_stall <= 1'b0;
    end
  end

  initial begin
    #4ms;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    int phase;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed words at reset defaults, then extreme register settings.
    send_word(sgdm_pkg::DMAX, sgdm_pkg::DMIN, sgdm_pkg::DMAX);
    send_word(sgdm_pkg::DMIN, sgdm_pkg::DMAX, sgdm_pkg::DMIN);
    send_word('0, '0, '0);
    send_word(-1, 1, -1);
    in_valid <= 1'b0;
    drain();
    write_reg(sgdm_pkg::REG_LR, 32'h7fff_ffff);
    write_reg(sgdm_pkg::REG_WD, 32'h8000_0000);
    write_reg(sgdm_pkg::REG_MOM, 32'h7fff_ffff);
    write_reg(sgdm_pkg::REG_DAMP, 32'h0100_0000);
    write_reg(sgdm_pkg::REG_SCALE, 32'h0);
    write_reg(sgdm_pkg::REG_MODE, 32'h1f);
    write_reg(REG_UNMAPPED, 32'hffff_ffff);
    send_word(sgdm_pkg::DMAX, sgdm_pkg::DMAX, sgdm_pkg::DMIN);
    send_word(sgdm_pkg::DMIN, sgdm_pkg::DMIN, sgdm_pkg::DMAX);
    send_word(32'h0100_0000, '0, 32'h0100_0000);
    in_valid <= 1'b0;
    drain();
    write_reg(sgdm_pkg::REG_MODE, 32'h3f);
    send_word(sgdm_pkg::DMAX, sgdm_pkg::DMIN, 32'h1234_5678);
    in_valid <= 1'b0;
    drain();
    write_reg(sgdm_pkg::REG_DAMP, 32'h01ff_ffff);
    write_reg(sgdm_pkg::REG_SCALE, 32'h7fff_ffff);
    write_reg(sgdm_pkg::REG_MODE, 32'h1a);
    send_word(32'h0100_0000, 32'h0200_0000, sgdm_pkg::DMIN);
    send_word(sgdm_pkg::DMIN, sgdm_pkg::DMAX, sgdm_pkg::DMAX);
    in_valid <= 1'b0;
    drain();
    write_reg(sgdm_pkg::REG_MODE, 32'h08);
    write_reg(sgdm_pkg::REG_WD, 32'h0);
    send_word(32'h0100_0000, 32'h0080_0000, 32'h0040_0000);
    in_valid <= 1'b0;
    drain();

    // Long receiver hold-off while the sender keeps offering words.
    hold_off <= 300;
    send_random(120);
    drain();

    for (phase = 0; phase < 10; phase++) begin
      random_config();
      stall_random = (phase % 3 != 2);
      send_random(95);
      drain();
    end

    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/sgdm_pkg.sv
design/sgdm_div.sv
design/sgdm_update.sv
design/sgd_momentum_update_core.sv
tb/sgd_momentum_update_checker.sv
tb/sgd_momentum_update_core_test.sv
